### hdl/zip_traditional_stream_decrypt_top_macros.svh
// assertion macros shared by the zipcrypto decrypt modules
`ifndef ZIP_TRADITIONAL_STREAM_DECRYPT_TOP_MACROS_SVH
`define ZIP_TRADITIONAL_STREAM_DECRYPT_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ZIPC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("zipc check failed");

// consequent must hold in the cycle after the antecedent
`define ZIPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("zipc check failed");

`endif

### hdl/zipc_pkg.sv
// package: constants, sequencer types and crc table for the zipcrypto decrypt block
package zipc_pkg;

    localparam int unsigned KEY_W      = 32;
    localparam int unsigned HCNT_W     = 4;

    localparam logic [KEY_W-1:0] KEY_A_INIT = 32'h1234_5678;
    localparam logic [KEY_W-1:0] KEY_B_INIT = 32'h2345_6789;
    localparam logic [KEY_W-1:0] KEY_C_INIT = 32'h3456_7890;
    localparam logic [KEY_W-1:0] LCG_MULT   = 32'd134775813;
    localparam logic [KEY_W-1:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [HCNT_W-1:0] HEADER_LEN = 4'd12;

    typedef enum logic [1:0] {
        S_IDLE,
        S_KS,
        S_LCG,
        S_KC
    } t_state;

    // sequencer to datapath controls
    typedef struct packed {
        logic ready;
        logic ks;
        logic lcg;
        logic kc_done;
    } t_ctrl;

    typedef logic [KEY_W-1:0] t_crc_table [256];

    function automatic t_crc_table f_crc_table();
        t_crc_table tbl;
        logic [KEY_W-1:0] r;
        for (int i = 0; i < 256; i++) begin
            r = KEY_W'(i);
            for (int j = 0; j < 8; j++) begin
                r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
            end
            tbl[i] = r;
        end
        return tbl;
    endfunction

    localparam t_crc_table CRC_TABLE = f_crc_table();

    // one crc-32 byte step through the table
    function automatic logic [KEY_W-1:0] f_crc_step(input logic [KEY_W-1:0] crc,
                                                    input logic [7:0] b);
        return (crc >> 8) ^ CRC_TABLE[crc[7:0] ^ b];
    endfunction

endpackage

### hdl/zipc_mul.sv
// shared 32x32 multiplier keeping the low word of the product
module zipc_mul (
    input  logic [zipc_pkg::KEY_W-1:0] i_a,
    input  logic [zipc_pkg::KEY_W-1:0] i_b,
    output logic [zipc_pkg::KEY_W-1:0] o_p
);

    // only the low word is ever used, so the product is taken at key width
    assign o_p = i_a * i_b;

endmodule

### hdl/zipc_seq.sv
// sequencer stepping each word through keystream, lcg and key_c phases
`include "zip_traditional_stream_decrypt_top_macros.svh"

module zipc_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_op,
    input  logic            i_out_busy,
    output zipc_pkg::t_ctrl o_ctrl
);
    import zipc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   kc_ok;
    logic   acc;

    // a result word can only land once the output register is free
    assign kc_ok = !i_op || !i_out_busy;

    always_comb begin
        o_ctrl.ready   = (r_state == S_IDLE) || ((r_state == S_KC) && kc_ok);
        o_ctrl.ks      = (r_state == S_KS);
        o_ctrl.lcg     = (r_state == S_LCG);
        o_ctrl.kc_done = (r_state == S_KC) && kc_ok;
    end

    assign acc = i_valid && o_ctrl.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) n_state = S_KS;
            end
            S_KS:  n_state = S_LCG;
            S_LCG: n_state = S_KC;
            S_KC: begin
                if (kc_ok) n_state = acc ? S_KS : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ZIPC_ASSERT_NEXT(a_acc_to_ks, acc, r_state == S_KS)
    `ZIPC_ASSERT_NEXT(a_ks_to_lcg, r_state == S_KS, r_state == S_LCG)
    `ZIPC_ASSERT_NEXT(a_lcg_to_kc, r_state == S_LCG, r_state == S_KC)

endmodule

### hdl/zip_traditional_stream_decrypt_top.sv
// traditional zip (zipcrypto) stream decrypt: key datapath and output register
// Usage:
// - input channel i_valid/o_stall carries one word: operation, start_req,
//   data_byte, last. operation 0 is a password byte (key setup, no result),
//   operation 1 is a ciphertext byte giving one result word.
// - start_req reloads the three keys and the header count before that word.
// - output channel o_valid/i_stall carries plain_byte, is_header,
//   end_of_entry and too_short for each ciphertext byte.
// - each word steps through the phases: keystream multiply plus key_a crc step, then
//   the lcg multiply on key_b, then key_c crc step and result write. one
//   32x32 multiplier and one crc table lookup are shared across the phases.
// - a result is written to the output register at the end of the key_c phase;
//   the next word is accepted in the key_c phase of the current one.
// - when the receiver stalls, the result holds in the output register and
//   the next ciphertext word runs to its last phase, then waits with o_stall high.
// - reset (synchronous, active low) loads the initial keys, clears the
//   header count, drops o_valid and leaves the block ready.
`include "zip_traditional_stream_decrypt_top_macros.svh"

module zip_traditional_stream_decrypt_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_operation,
    input  logic       i_start_req,
    input  logic [7:0] i_data_byte,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_plain_byte,
    output logic       o_is_header,
    output logic       o_end_of_entry,
    output logic       o_too_short
);
    import zipc_pkg::*;

    t_ctrl ctrl;
    logic  in_acc;

    logic             r_op;
    logic             r_start;
    logic [7:0]       r_data;
    logic             r_last;
    logic [KEY_W-1:0] r_key_a;
    logic [KEY_W-1:0] r_key_b;
    logic [KEY_W-1:0] r_key_c;
    logic [HCNT_W-1:0] r_hcnt;
    logic             r_out_valid;
    logic [7:0]       r_plain;
    logic [7:0]       r_out_plain;
    logic             r_out_hdr;
    logic             r_out_end;
    logic             r_out_short;

    logic [KEY_W-1:0] sel_a;
    logic [KEY_W-1:0] sel_b;
    logic [KEY_W-1:0] sel_c;
    logic [15:0]      ks_t;
    logic [KEY_W-1:0] mul_a;
    logic [KEY_W-1:0] mul_b;
    logic [KEY_W-1:0] mul_p;
    logic [7:0]       upd_byte;
    logic [KEY_W-1:0] kb_inc;
    logic [KEY_W-1:0] crc_in;
    logic [7:0]       crc_byte;
    logic [KEY_W-1:0] crc_out;

    zipc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_op       (r_op),
        .i_out_busy (r_out_valid && i_stall),
        .o_ctrl     (ctrl)
    );

    assign o_stall = !ctrl.ready;
    assign in_acc  = i_valid && ctrl.ready;

    // start applies in the keystream phase so a word taken during key_c update works
    assign sel_a = r_start ? KEY_A_INIT : r_key_a;
    assign sel_b = r_start ? KEY_B_INIT : r_key_b;
    assign sel_c = r_start ? KEY_C_INIT : r_key_c;

    assign ks_t  = sel_c[15:0] | 16'h0002;
    assign mul_a = ctrl.ks ? {16'b0, ks_t} : (r_key_b + {24'b0, r_key_a[7:0]});
    assign mul_b = ctrl.ks ? {16'b0, ks_t ^ 16'h0001} : LCG_MULT;

    zipc_mul u_mul (
        .i_a (mul_a),
        .i_b (mul_b),
        .o_p (mul_p)
    );

    assign upd_byte = r_op ? (r_data ^ mul_p[15:8]) : r_data;
    assign kb_inc   = r_key_b + 32'd1;

    // one table step serves key_a in the keystream phase and key_c at the end
    assign crc_in   = ctrl.ks ? sel_a : r_key_c;
    assign crc_byte = ctrl.ks ? upd_byte : kb_inc[31:24];
    assign crc_out  = f_crc_step(crc_in, crc_byte);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= i_operation;
            r_start <= i_start_req;
            r_data  <= i_data_byte;
            r_last  <= i_last;
        end
        if (ctrl.ks) begin
            r_plain <= upd_byte;
        end
        if (ctrl.kc_done && r_op) begin
            r_out_plain <= r_plain;
            r_out_hdr   <= (r_hcnt < HEADER_LEN);
            r_out_end   <= r_last;
            r_out_short <= r_last && (r_hcnt < (HEADER_LEN - 4'd1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_a     <= KEY_A_INIT;
            r_key_b     <= KEY_B_INIT;
            r_key_c     <= KEY_C_INIT;
            r_hcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ctrl.ks) begin
                r_key_a <= crc_out;
                r_key_b <= sel_b;
                r_key_c <= sel_c;
                if (r_start) r_hcnt <= '0;
            end
            if (ctrl.lcg) begin
                r_key_b <= mul_p;
            end
            if (ctrl.kc_done) begin
                r_key_b <= kb_inc;
                r_key_c <= crc_out;
                if (r_op && (r_hcnt < HEADER_LEN)) r_hcnt <= r_hcnt + 4'd1;
            end
            if (ctrl.kc_done && r_op) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_plain_byte   = r_out_plain;
    assign o_is_header    = r_out_hdr;
    assign o_end_of_entry = r_out_end;
    assign o_too_short    = r_out_short;

    `ZIPC_ASSERT_NOW(a_hcnt_sat, 1'b1, r_hcnt <= HEADER_LEN)
    `ZIPC_ASSERT_NEXT(a_result_loads, ctrl.kc_done && r_op, o_valid)
    `ZIPC_ASSERT_NOW(a_short_only_end, o_valid && o_too_short, o_end_of_entry && o_is_header)

endmodule

### bench/tb_zip_traditional_stream_decrypt_top.sv
// testbench for the zipcrypto stream decrypt block: random entries, own key model, in-order check
module tb_zip_traditional_stream_decrypt_top;
    import zipc_pkg::*;

    localparam logic OP_PASSWORD = 1'b0;
    localparam logic OP_CIPHER   = 1'b1;
    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned RANDOM_WORDS = 1150;

    typedef struct {
        logic       operation;
        logic       start_req;
        logic [7:0] data_byte;
        logic       last;
    } t_cipher_word;

    typedef struct {
        logic [7:0] plain_byte;
        logic       is_header;
        logic       end_of_entry;
        logic       too_short;
    } t_plain_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_operation = 1'b0;
    logic       in_start_req = 1'b0;
    logic [7:0] in_data_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       out_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_plain_byte;
    logic       o_is_header;
    logic       o_end_of_entry;
    logic       o_too_short;

    t_cipher_word word_queue[$];
    t_plain_word  plain_expected[$];

    // model state
    logic [KEY_W-1:0]  key_a = KEY_A_INIT;
    logic [KEY_W-1:0]  key_b = KEY_B_INIT;
    logic [KEY_W-1:0]  key_c = KEY_C_INIT;
    logic [HCNT_W-1:0] hdr_seen = '0;

    logic        in_taken = 1'b0;
    int unsigned accepted_in = 0;
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    int unsigned cyc_count = 0;
    bit          hold_done = 1'b0;

    zip_traditional_stream_decrypt_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (in_valid),
        .o_stall        (o_stall),
        .i_operation    (in_operation),
        .i_start_req    (in_start_req),
        .i_data_byte    (in_data_byte),
        .i_last         (in_last),
        .o_valid        (o_valid),
        .i_stall        (out_stall),
        .o_plain_byte   (o_plain_byte),
        .o_is_header    (o_is_header),
        .o_end_of_entry (o_end_of_entry),
        .o_too_short    (o_too_short)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // bitwise reflected crc-32 over one byte
    function automatic logic [KEY_W-1:0] crc8_step(input logic [KEY_W-1:0] crc,
                                                   input logic [7:0] b);
        logic [KEY_W-1:0] r;
        r = crc ^ {24'h0, b};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    task automatic mix_keys(input logic [7:0] b);
        key_a = crc8_step(key_a, b);
        key_b = (key_b + {24'h0, key_a[7:0]}) * LCG_MULT + 32'd1;
        key_c = crc8_step(key_c, key_b[31:24]);
    endtask

    task automatic decrypt_word(input t_cipher_word w);
        logic [15:0] t;
        logic [31:0] prod;
        t_plain_word p;
        if (w.start_req) begin
            key_a = KEY_A_INIT;
            key_b = KEY_B_INIT;
            key_c = KEY_C_INIT;
            hdr_seen = '0;
        end
        if (w.operation == OP_CIPHER) begin
            t = key_c[15:0] | 16'h0002;
            prod = {16'h0, t} * {16'h0, t ^ 16'h0001};
            p.plain_byte = w.data_byte ^ prod[15:8];
            mix_keys(p.plain_byte);
            p.is_header = (hdr_seen < HEADER_LEN);
            p.end_of_entry = w.last;
            p.too_short = w.last && (hdr_seen < HEADER_LEN - 4'd1);
            if (hdr_seen < HEADER_LEN) begin
                hdr_seen = hdr_seen + 4'd1;
            end
            plain_expected.insert(plain_expected.size(), p);
        end else begin
            mix_keys(w.data_byte);
        end
    endtask

    task automatic add_word(input logic op, input logic st, input logic [7:0] d,
                            input logic lst);
        t_cipher_word w;
        w.operation = op;
        w.start_req = st;
        w.data_byte = d;
        w.last = lst;
        word_queue.insert(word_queue.size(), w);
    endtask

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // sender: next word at the falling edge once the current one was taken
    always @(negedge i_clk) begin : sender
        logic nxt_valid;
        t_cipher_word w;
        nxt_valid = in_valid;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (in_valid && in_taken) begin
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (word_queue.size() > 0) begin
                    w = word_queue.pop_front();
                    in_operation <= w.operation;
                    in_start_req <= w.start_req;
                    in_data_byte <= w.data_byte;
                    in_last <= w.last;
                    nxt_valid = 1'b1;
                    gap_left = ((accepted_in % 160) < 30) ? 0 : pick_gap();
                end
            end
        end
        in_valid <= nxt_valid;
    end

    // receiver stall, with one long hold-off to back the block up
    always @(negedge i_clk) begin : receiver
        logic nxt;
        cyc_count++;
        nxt = 1'b0;
        if (hold_left > 0) begin
            hold_left--;
            nxt = 1'b1;
        end else if (!hold_done && accepted_in >= 400) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            nxt = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            nxt = 1'b1;
        end else if ((cyc_count % 256) >= 40 && $urandom_range(0, 2) == 0) begin
            stall_left = pick_gap();
            if (stall_left > 0) begin
                stall_left--;
                nxt = 1'b1;
            end
        end
        out_stall <= nxt;
    end

    // predict on input word, check on output word
    always @(posedge i_clk) begin : monitor
        t_cipher_word w;
        t_plain_word p;
        if (i_rst_n) begin
            if (in_valid && !o_stall) begin
                w.operation = in_operation;
                w.start_req = in_start_req;
                w.data_byte = in_data_byte;
                w.last = in_last;
                decrypt_word(w);
                accepted_in++;
                in_taken <= 1'b1;
            end else begin
                in_taken <= 1'b0;
            end
            if (o_valid && !out_stall) begin
                if (plain_expected.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected word: plain %h hdr %b end %b short %b",
                                 o_plain_byte, o_is_header, o_end_of_entry, o_too_short);
                    end
                    mismatches++;
                end else begin
                    p = plain_expected.pop_front();
                    if (o_plain_byte !== p.plain_byte || o_is_header !== p.is_header ||
                        o_end_of_entry !== p.end_of_entry || o_too_short !== p.too_short) begin
                        if (mismatches < 10) begin
                            $display("mismatch: exp plain %h hdr %b end %b short %b",
                                     p.plain_byte, p.is_header, p.end_of_entry,
                                     p.too_short);
                            $display("          got plain %h hdr %b end %b short %b",
                                     o_plain_byte, o_is_header, o_end_of_entry,
                                     o_too_short);
                        end
                        mismatches++;
                    end
                end
            end
        end else begin
            in_taken <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((in_valid && !o_stall) || (o_valid && !out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("zip_traditional_stream_decrypt_top verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned pw_len;
        int unsigned ct_len;
        int unsigned r;
        int unsigned n;
        bit          st;

        // directed: extremes, start on both operations, short and full entries
        add_word(OP_PASSWORD, 1'b1, 8'h00, 1'b0);
        add_word(OP_PASSWORD, 1'b0, 8'hFF, 1'b1);          // last on password is ignored
        add_word(OP_PASSWORD, 1'b0, 8'h5A, 1'b0);
        add_word(OP_CIPHER,   1'b0, 8'h00, 1'b0);
        add_word(OP_CIPHER,   1'b0, 8'hFF, 1'b1);          // entry ends too short
        add_word(OP_CIPHER,   1'b0, 8'h12, 1'b0);          // carries on after last
        add_word(OP_PASSWORD, 1'b0, 8'h33, 1'b0);          // password after ciphertext
        add_word(OP_CIPHER,   1'b1, 8'hAA, 1'b0);          // start on a ciphertext word
        for (int i = 0; i < 11; i++) begin
            add_word(OP_CIPHER, 1'b0, 8'($urandom), (i == 10));  // last on twelfth byte
        end
        add_word(OP_CIPHER,   1'b0, 8'h80, 1'b0);          // header count saturated
        add_word(OP_CIPHER,   1'b0, 8'h7F, 1'b1);
        add_word(OP_CIPHER,   1'b1, 8'h01, 1'b1);          // one-byte entry
        add_word(OP_PASSWORD, 1'b1, 8'hFF, 1'b0);
        for (int i = 0; i < 3; i++) begin
            add_word(OP_CIPHER, 1'b0, 8'($urandom), 1'b0);
        end

        // random: mostly well-formed entries, some noise
        n = 0;
        while (n < RANDOM_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 85) begin
                pw_len = $urandom_range(1, 12);
                for (int i = 0; i < pw_len; i++) begin
                    st = (i == 0) && ($urandom_range(0, 9) != 0);
                    add_word(OP_PASSWORD, st, 8'($urandom), ($urandom_range(0, 15) == 0));
                end
                r = $urandom_range(0, 9);
                if (r < 2) ct_len = $urandom_range(1, 11);
                else if (r < 5) ct_len = $urandom_range(11, 13);
                else ct_len = $urandom_range(14, 40);
                for (int j = 0; j < ct_len; j++) begin
                    add_word(OP_CIPHER, 1'b0, 8'($urandom), (j == ct_len - 1));
                end
                n += pw_len + ct_len;
            end else begin
                r = $urandom_range(1, 8);
                for (int i = 0; i < r; i++) begin
                    add_word(1'($urandom), ($urandom_range(0, 7) == 0), 8'($urandom),
                             1'($urandom));
                end
                n += r;
            end
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (word_queue.size() != 0 || in_valid || plain_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);

        if (mismatches == 0 && plain_expected.size() == 0) begin
            $display("zip_traditional_stream_decrypt_top verification clean");
        end else begin
            $display("zip_traditional_stream_decrypt_top verification failed");
        end
        $finish;
    end

endmodule
